// ===== rtl/color_key_sprite_run_encoder_assert.svh =====
// Assertion macros shared by the color-key sprite run encoder modules.
`ifndef COLOR_KEY_SPRITE_RUN_ENCODER_ASSERT_SVH
`define COLOR_KEY_SPRITE_RUN_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define CKSRE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define CKSRE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CKSRE_ASSERT_IMP(label, ante, cons)
`define CKSRE_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/cksre_pkg.sv =====
// Shared constants, word kinds and control/status structs of the sprite run encoder.
package cksre_pkg;

  localparam int DEF_MAX_WIDTH  = 32;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int PIX_W      = 16;
  localparam int KEY_W      = 16;
  localparam int CFG_WID_W  = 6;
  localparam int CFG_HGT_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int KIND_W     = 3;
  localparam int VALUE_W    = 16;
  localparam int ROW_OUT_W  = 10;
  localparam int CMP_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KEY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [KEY_W-1:0]     KEY_RESET    = 16'd0;
  localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = 6'd32;
  localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = 11'd1024;

  localparam logic [KIND_W-1:0] KIND_LEN   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COL   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PIX   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ROW   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TOTAL = 3'd4;

  localparam logic [VALUE_W-1:0] INDEX_MAX = 16'hFFFF;

  typedef struct packed {
    logic              accept;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              last;
    logic              sprite_end;
  } cmd_t;

  typedef struct packed {
    logic opaque;
    logic row_end;
    logic sprite_end;
    logic run_nonzero;
    logic last_pix;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/cksre_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cksre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/cksre_ctrl.sv =====
// Controller state machine: accepts pixels and sequences the emitted words.
`include "color_key_sprite_run_encoder_assert.svh"
module cksre_ctrl
  import cksre_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_COL  = 3'd2;
  localparam logic [2:0] S_PIX  = 3'd3;
  localparam logic [2:0] S_ROW  = 3'd4;
  localparam logic [2:0] S_TOT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       row_end;
  logic       sprite_end;
  logic       flush;

  assign in_ready = (state == S_IDLE);
  // The run is dumped if this pixel closes it, by a key pixel or by the row end.
  assign flush = sts.opaque ? sts.row_end : sts.run_nonzero;

  always_comb begin
    state_next     = state;
    cmd.accept     = 1'b0;
    cmd.emit       = 1'b0;
    cmd.kind       = KIND_LEN;
    cmd.last       = 1'b0;
    cmd.sprite_end = sprite_end;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (flush) begin
            state_next = S_LEN;
          end else if (sts.row_end) begin
            state_next = S_ROW;
          end
        end
      end
      S_LEN: begin
        cmd.kind = KIND_LEN;
        cmd.emit = sts.out_free;
        if (sts.out_free) begin
          state_next = S_COL;
        end
      end
      S_COL: begin
        cmd.kind = KIND_COL;
        cmd.emit = sts.out_free;
        if (sts.out_free) begin
          state_next = S_PIX;
        end
      end
      S_PIX: begin
        cmd.kind = KIND_PIX;
        cmd.emit = sts.out_free;
        cmd.last = sts.last_pix && !row_end;
        if (sts.out_free && sts.last_pix) begin
          state_next = row_end ? S_ROW : S_IDLE;
        end
      end
      S_ROW: begin
        cmd.kind = KIND_ROW;
        cmd.emit = sts.out_free;
        cmd.last = !sprite_end;
        if (sts.out_free) begin
          state_next = sprite_end ? S_TOT : S_IDLE;
        end
      end
      S_TOT: begin
        cmd.kind = KIND_TOTAL;
        cmd.emit = sts.out_free;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      row_end    <= 1'b0;
      sprite_end <= 1'b0;
    end else begin
      state <= state_next;
      // Hold the row and sprite end decisions for the whole burst.
      if (cmd.accept) begin
        row_end    <= sts.row_end;
        sprite_end <= sts.sprite_end;
      end
    end
  end

  `CKSRE_ASSERT_IMP(a_emit_needs_slot, cmd.emit, sts.out_free)
  `CKSRE_ASSERT_IMP(a_pix_has_run, state == S_PIX, sts.run_nonzero)
  `CKSRE_ASSERT_NXT(a_last_ends_burst, cmd.emit && cmd.last, state == S_IDLE)

endmodule

// ===== rtl/cksre_dp.sv =====
// Datapath: configuration, run buffer, position and index counters, output register.
`include "color_key_sprite_run_encoder_assert.svh"
module cksre_dp
  import cksre_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [PIX_W-1:0]      pixel,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     word_kind,
  output logic [VALUE_W-1:0]    word_value,
  output logic                  row_empty,
  output logic [ROW_OUT_W-1:0]  row_number,
  output logic                  last_of_burst
);

  localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LEN_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [KEY_W-1:0]     key;
  logic [CFG_WID_W-1:0] width;
  logic [CFG_HGT_W-1:0] height;

  logic [LEN_W-1:0]   run_len;
  logic [IDX_W-1:0]   run_start;
  logic [IDX_W-1:0]   column;
  logic [ROW_W-1:0]   row;
  logic [VALUE_W-1:0] write_index;
  logic [VALUE_W-1:0] row_first;
  logic               row_has_seg;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_next;
  logic [PIX_W-1:0]   rd_data;
  logic               buf_wr;

  logic [CMP_W-1:0]   w_eff;
  logic [CMP_W-1:0]   h_eff;
  logic               index_step;
  logic               row_word;

  logic [VALUE_W-1:0]   out_value;
  logic                 out_empty;
  logic [ROW_OUT_W-1:0] out_row;

  // Clamp geometry to 1..MAX.
  always_comb begin
    if (width == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(width) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(width);
    end
    if (height == '0) begin
      h_eff = CMP_W'(1);
    end else if (CMP_W'(height) > CMP_W'(MAX_HEIGHT)) begin
      h_eff = CMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = CMP_W'(height);
    end
  end

  assign sts.opaque      = (pixel != key);
  assign sts.row_end     = (CMP_W'(column) + CMP_W'(1)) >= w_eff;
  assign sts.sprite_end  = (CMP_W'(row) + CMP_W'(1)) >= h_eff;
  assign sts.run_nonzero = (run_len != '0);
  assign sts.last_pix    = (LEN_W'(idx) == (run_len - LEN_W'(1)));
  assign sts.out_free    = !out_valid || out_ready;

  assign buf_wr = cmd.accept && sts.opaque && (run_len < LEN_W'(MAX_WIDTH));

  // Read address runs one step ahead so the registered data matches idx.
  always_comb begin
    idx_next = idx;
    if (cmd.emit && (cmd.kind == KIND_LEN)) begin
      idx_next = '0;
    end else if (cmd.emit && (cmd.kind == KIND_PIX) && !sts.last_pix) begin
      idx_next = idx + IDX_W'(1);
    end
  end

  cksre_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_run_buf (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_addr (run_len[IDX_W-1:0]),
    .wr_data (pixel),
    .rd_addr (idx_next),
    .rd_data (rd_data)
  );

  assign index_step = cmd.emit &&
                      ((cmd.kind == KIND_LEN) || (cmd.kind == KIND_COL) ||
                       (cmd.kind == KIND_PIX));

  assign row_word = cmd.emit && (cmd.kind == KIND_ROW) && row_has_seg;

  always_comb begin
    out_value = '0;
    out_empty = 1'b0;
    out_row   = '0;
    case (cmd.kind)
      KIND_LEN:   out_value = VALUE_W'(run_len);
      KIND_COL:   out_value = VALUE_W'(run_start);
      KIND_PIX:   out_value = rd_data;
      KIND_ROW: begin
        out_value = row_has_seg ? row_first : '0;
        out_empty = !row_has_seg;
        out_row   = ROW_OUT_W'(row);
      end
      KIND_TOTAL: out_value = write_index;
      default:    out_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key         <= KEY_RESET;
      width       <= WIDTH_RESET;
      height      <= HEIGHT_RESET;
      run_len     <= '0;
      run_start   <= '0;
      column      <= '0;
      row         <= '0;
      write_index <= '0;
      row_first   <= '0;
      row_has_seg <= 1'b0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      idx <= idx_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_KEY:    key    <= cfg_data[KEY_W-1:0];
          REG_WIDTH:  width  <= cfg_data[CFG_WID_W-1:0];
          REG_HEIGHT: height <= cfg_data[CFG_HGT_W-1:0];
          default: begin
            // drop writes to unknown registers
          end
        endcase
      end
      if (cmd.accept) begin
        column <= sts.row_end ? '0 : column + IDX_W'(1);
        if (sts.opaque) begin
          if (run_len == '0) begin
            run_start <= column;
            if (!row_has_seg) begin
              row_first   <= write_index;
              row_has_seg <= 1'b1;
            end
          end
          if (run_len < LEN_W'(MAX_WIDTH)) begin
            run_len <= run_len + LEN_W'(1);
          end
        end
      end
      if (index_step && (write_index != INDEX_MAX)) begin
        write_index <= write_index + VALUE_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        case (cmd.kind)
          KIND_PIX: begin
            if (sts.last_pix) begin
              run_len <= '0;
            end
          end
          KIND_ROW: begin
            row_has_seg <= 1'b0;
            row_first   <= '0;
            row         <= cmd.sprite_end ? '0 : row + ROW_W'(1);
          end
          KIND_TOTAL: begin
            write_index <= '0;
            run_len     <= '0;
            run_start   <= '0;
          end
          default: begin
            // length and column words change nothing else
          end
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      word_kind     <= cmd.kind;
      word_value    <= out_value;
      row_empty     <= out_empty;
      row_number    <= out_row;
      last_of_burst <= cmd.last;
    end
  end

  `CKSRE_ASSERT_IMP(a_run_len_bound, 1'b1, run_len <= LEN_W'(MAX_WIDTH))
  `CKSRE_ASSERT_IMP(a_row_first_behind, row_word, row_first <= write_index)

endmodule

// ===== rtl/color_key_sprite_run_encoder.sv =====
// A pixel is taken only while the controller is idle, so no new pixel is taken during a burst;
// a pixel that ends nothing leaves the controller idle. The words of a burst leave
// one word per cycle from the single output register while the sink is ready.
// A flushed run of n pixels gives n + 2 words; row entry and total add one each.
// Reset is synchronous, active high; it clears counters and restores register defaults.
module color_key_sprite_run_encoder
  import cksre_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     word_kind,
  output logic [VALUE_W-1:0]    word_value,
  output logic                  row_empty,
  output logic [ROW_OUT_W-1:0]  row_number,
  output logic                  last_of_burst
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cksre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cksre_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel         (pixel),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .word_kind     (word_kind),
    .word_value    (word_value),
    .row_empty     (row_empty),
    .row_number    (row_number),
    .last_of_burst (last_of_burst)
  );

endmodule

// ===== tb/sv/color_key_sprite_run_encoder_tb.sv =====
// Self-checking testbench for the color-key sprite run encoder.
module color_key_sprite_run_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cksre_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [VALUE_W-1:0]   value;
    logic                 empty;
    logic [ROW_OUT_W-1:0] row;
    logic                 last;
  } word_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [KIND_W-1:0]     word_kind;
  logic [VALUE_W-1:0]    word_value;
  logic                  row_empty;
  logic [ROW_OUT_W-1:0]  row_number;
  logic                  last_of_burst;

  color_key_sprite_run_encoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel        (pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word_kind    (word_kind),
    .word_value   (word_value),
    .row_empty    (row_empty),
    .row_number   (row_number),
    .last_of_burst(last_of_burst)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL color_key_sprite_run_encoder");
    $finish;
  end

  // Encoder image: registers and run state.
  logic [KEY_W-1:0]     key_color  = KEY_RESET;
  logic [CFG_WID_W-1:0] width_reg  = WIDTH_RESET;
  logic [CFG_HGT_W-1:0] height_reg = HEIGHT_RESET;
  logic [PIX_W-1:0]     run_buf [DEF_MAX_WIDTH];
  logic [5:0]           run_len   = '0;
  logic [4:0]           run_col   = '0;
  logic [4:0]           col_cnt   = '0;
  logic [9:0]           row_cnt   = '0;
  logic [VALUE_W-1:0]   write_idx = '0;
  logic [VALUE_W-1:0]   first_idx = '0;
  logic                 row_open  = 1'b0;

  word_t            pending_words [$];
  logic [PIX_W-1:0] pixel_q [$];
  int               pixels_queued = 0;
  int               pixels_taken  = 0;
  int               cfg_writes    = 0;
  int               errors        = 0;
  logic             pixel_accepted = 1'b0;
  logic             no_gaps = 1'b0;
  int               in_gap_left = 0;
  int               stall_left  = 0;

  function automatic void push_word(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                                    logic empty, logic [ROW_OUT_W-1:0] rownum, logic adv);
    word_t w;
    w.kind  = kind;
    w.value = value;
    w.empty = empty;
    w.row   = rownum;
    w.last  = 1'b0;
    pending_words.push_back(w);
    if (adv && write_idx != INDEX_MAX) write_idx++;
  endfunction

  function automatic void flush_run();
    if (run_len == 0) return;
    push_word(KIND_LEN, VALUE_W'(run_len), 1'b0, '0, 1'b1);
    push_word(KIND_COL, VALUE_W'(run_col), 1'b0, '0, 1'b1);
    for (int i = 0; i < run_len; i++) push_word(KIND_PIX, run_buf[i], 1'b0, '0, 1'b1);
    run_len = '0;
  endfunction

  function automatic void encode_pixel(logic [PIX_W-1:0] pix);
    int    w;
    int    h;
    int    n0;
    word_t tail;
    w  = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
    h  = (height_reg == 0) ? 1 :
         (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
    n0 = pending_words.size();
    if (pix != key_color) begin
      if (run_len == 0) begin
        run_col = col_cnt;
        if (!row_open) begin
          first_idx = write_idx;
          row_open  = 1'b1;
        end
      end
      if (run_len < DEF_MAX_WIDTH) begin
        run_buf[run_len] = pix;
        run_len++;
      end
    end else begin
      flush_run();
    end
    if (int'(col_cnt) + 1 >= w) begin
      flush_run();
      push_word(KIND_ROW, row_open ? first_idx : '0, !row_open, row_cnt, 1'b0);
      col_cnt   = '0;
      row_open  = 1'b0;
      first_idx = '0;
      if (int'(row_cnt) + 1 >= h) begin
        push_word(KIND_TOTAL, write_idx, 1'b0, '0, 1'b0);
        row_cnt   = '0;
        write_idx = '0;
        run_len   = '0;
        run_col   = '0;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
    // mark the closing word of this pixel's burst
    if (pending_words.size() > n0) begin
      tail = pending_words.pop_back();
      tail.last = 1'b1;
      pending_words.push_back(tail);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 30);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(logic [PIX_W-1:0] k, int opaque_pct);
    logic [PIX_W-1:0] p;
    if ($urandom_range(1, 100) > opaque_pct) return k;
    case ($urandom_range(0, 9))
      0:       p = '0;
      1:       p = '1;
      default: p = PIX_W'($urandom);
    endcase
    if (p == k) p[0] = ~p[0];
    return p;
  endfunction

  // Monitor: register writes, accepted pixels and output words.
  always @(posedge clk) begin : monitor
    word_t want;
    if (rst) begin
      pixel_accepted <= 1'b0;
    end else begin
      pixel_accepted <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY:    key_color  = cfg_data;
          REG_WIDTH:  width_reg  = cfg_data[CFG_WID_W-1:0];
          REG_HEIGHT: height_reg = cfg_data[CFG_HGT_W-1:0];
          default: ;
        endcase
        cfg_writes <= cfg_writes + 1;
      end
      if (in_valid && in_ready) begin
        encode_pixel(pixel);
        pixels_taken <= pixels_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          if (errors < 10)
            $display("unexpected word: kind %0d value %h empty %b row %0d last %b",
                     word_kind, word_value, row_empty, row_number, last_of_burst);
          errors++;
        end else begin
          want = pending_words.pop_front();
          if (word_kind !== want.kind || word_value !== want.value ||
              row_empty !== want.empty || row_number !== want.row ||
              last_of_burst !== want.last) begin
            if (errors < 10)
              $display("word mismatch: exp kind %0d value %h empty %b row %0d last %b, %s",
                       want.kind, want.value, want.empty, want.row, want.last,
                       $sformatf("got kind %0d value %h empty %b row %0d last %b",
                                 word_kind, word_value, row_empty, row_number,
                                 last_of_burst));
            errors++;
          end
        end
      end
    end
  end

  // Pixel driver: hold until the transaction completes, then idle or send the next one.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !pixel_accepted) begin
      // hold
    end else if (in_gap_left > 0) begin
      in_valid    <= 1'b0;
      in_gap_left <= in_gap_left - 1;
    end else if (pixel_q.size() > 0) begin
      in_valid    <= 1'b1;
      pixel       <= pixel_q.pop_front();
      in_gap_left <= no_gaps ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Sink: stall at random.
  always @(negedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= (no_gaps || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int seen;
    @(negedge clk);
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] p);
    pixel_q.push_back(p);
    pixels_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pixels_taken != pixels_queued || pending_words.size() != 0);
    // a pixel that ends nothing still updates state inside the block
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] directed [24];
    logic [PIX_W-1:0] k;
    int w;
    int h;
    int n;
    int pct;
    int random_count;
    directed = '{
      16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h0000, 16'h0000, 16'h1234, 16'h7FFF,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 16'hFFFE, 16'h7FFF, 16'h1234
    };
    random_count = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // runs cut by key pixels and by row end, an empty row, a full row, sprite total
    write_reg(REG_KEY, 16'h0000);
    write_reg(REG_WIDTH, 16'd8);
    write_reg(REG_HEIGHT, 16'd3);
    write_reg(REG_UNUSED, 16'hFFFF);
    foreach (directed[i]) send_pixel(directed[i]);
    wait_idle();

    // zero width and height act as one
    write_reg(REG_KEY, 16'hFFFF);
    write_reg(REG_WIDTH, {10'($urandom), 6'd0});
    write_reg(REG_HEIGHT, {5'($urandom), 11'd0});
    repeat (6) send_pixel(pick_pixel(16'hFFFF, 50));
    wait_idle();

    // oversized width saturates
    k = 16'($urandom);
    write_reg(REG_KEY, k);
    write_reg(REG_WIDTH, {10'($urandom), 6'd63});
    write_reg(REG_HEIGHT, {5'($urandom), 11'd2});
    repeat (33) send_pixel(pick_pixel(k, 90));
    wait_idle();

    // one full-width opaque row: the longest burst
    write_reg(REG_WIDTH, {10'($urandom), 6'd32});
    write_reg(REG_HEIGHT, {5'($urandom), 11'd1});
    repeat (32) send_pixel(pick_pixel(k, 100));
    wait_idle();

    // shrink width, then height, in the middle of a sprite
    k = 16'h8000;
    write_reg(REG_KEY, k);
    write_reg(REG_WIDTH, 16'd16);
    write_reg(REG_HEIGHT, 16'd4);
    repeat (10) send_pixel(pick_pixel(k, 60));
    wait_idle();
    write_reg(REG_WIDTH, 16'd5);
    repeat (12) send_pixel(pick_pixel(k, 60));
    wait_idle();
    write_reg(REG_HEIGHT, 16'd1);
    repeat (5) send_pixel(pick_pixel(k, 60));
    wait_idle();

    while (random_count < 36) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
      h = $urandom_range(1, 4);
      case ($urandom_range(0, 3))
        0:       k = '0;
        1:       k = '1;
        default: k = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       pct = 25;
        1:       pct = 60;
        2:       pct = 85;
        default: pct = 100;
      endcase
      // mostly whole sprites, sometimes stop part way
      n = ($urandom_range(0, 3) != 0) ? w * h : $urandom_range(1, w * h);
      if (n > 36 - random_count) n = 36 - random_count;
      no_gaps = ($urandom_range(0, 3) == 0);
      write_reg(REG_KEY, k);
      write_reg(REG_WIDTH, {10'($urandom), 6'(w)});
      write_reg(REG_HEIGHT, {5'($urandom), 11'(h)});
      repeat (n) send_pixel(pick_pixel(k, pct));
      random_count += n;
      wait_idle();
    end
    no_gaps = 1'b0;

    // oversized height: the first rows of a tall single-column sprite
    k = 16'($urandom);
    write_reg(REG_KEY, k);
    write_reg(REG_WIDTH, {10'($urandom), 6'd1});
    write_reg(REG_HEIGHT, {5'($urandom), 11'h7FF});
    repeat (6) send_pixel(pick_pixel(k, 50));
    wait_idle();

    repeat (20) @(negedge clk);
    if (pending_words.size() != 0) errors++;
    if (errors == 0) begin
      $display("PASS color_key_sprite_run_encoder");
    end else begin
      $display("FAIL color_key_sprite_run_encoder");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cksre_pkg.sv
rtl/cksre_ram.sv
rtl/cksre_ctrl.sv
rtl/cksre_dp.sv
rtl/color_key_sprite_run_encoder.sv
tb/sv/color_key_sprite_run_encoder_tb.sv
